FILE: rtl/core/necir_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
package necir_pkg;

  // Width of one captured interval in microseconds
  localparam int INTERVAL_BITS = 16;

  // Leader mark, leader space and both data-space windows (center +/- tolerance)
  localparam int LEADER_MARK_LO  = 9000 - 2250;
  localparam int LEADER_MARK_HI  = 9000 + 2250;
  localparam int LEADER_SPACE_LO = 4500 - 1125;
  localparam int LEADER_SPACE_HI = 4500 + 1125;
  localparam int SHORT_LO        = 562 - 400;
  localparam int SHORT_HI        = 562 + 400;
  localparam int LONG_LO         = 1688 - 422;
  localparam int LONG_HI         = 1688 + 422;

  // Two leader intervals plus 32 mark/space pairs
  localparam int FRAME_INTERVALS = 66;
  localparam int POS_BITS        = 7;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_LEADER   = 3'd2,
    ST_BAD_BIT      = 3'd3,
    ST_INV_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LEADER = 2'd1,
    ERR_BIT    = 2'd2
  } err_t;

  typedef struct packed {
    logic [INTERVAL_BITS-1:0] interval_us;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [31:0] code_word;
  } out_beat_t;

  // Window hits of one interval, independent of its place in the frame
  typedef struct packed {
    logic leader_mark_ok;
    logic leader_space_ok;
    logic short_ok;
    logic long_ok;
    logic last;
  } class_t;

endpackage

FILE: rtl/core/necir_front.sv
// Front end: sorts each interval into the timing windows it falls in.
module necir_front (
  input  necir_pkg::in_beat_t in_data,
  output necir_pkg::class_t   cls
);
  import necir_pkg::*;

  logic [INTERVAL_BITS-1:0] t;

  assign t = in_data.interval_us;

  // Compare against every window at once
  assign cls.leader_mark_ok  = (t >= INTERVAL_BITS'(LEADER_MARK_LO)) &&
                               (t <= INTERVAL_BITS'(LEADER_MARK_HI));
  assign cls.leader_space_ok = (t >= INTERVAL_BITS'(LEADER_SPACE_LO)) &&
                               (t <= INTERVAL_BITS'(LEADER_SPACE_HI));
  assign cls.short_ok        = (t >= INTERVAL_BITS'(SHORT_LO)) &&
                               (t <= INTERVAL_BITS'(SHORT_HI));
  assign cls.long_ok         = (t >= INTERVAL_BITS'(LONG_LO)) &&
                               (t <= INTERVAL_BITS'(LONG_HI));
  assign cls.last            = in_data.last;

endmodule

FILE: rtl/core/necir_queue.sv
// Two-entry queue of classified intervals between front and back end.
module necir_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  necir_pkg::class_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output necir_pkg::class_t head_data
);
  import necir_pkg::*;

  localparam int DEPTH    = 2;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  class_t                entry_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_BITS'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entry payloads without reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/necir_back.sv
// Back end: frame position tracking, bit assembly and result register.
module necir_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  necir_pkg::class_t    head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output necir_pkg::out_beat_t out_data
);
  import necir_pkg::*;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]         frame_r, frame_nxt;
  logic                mark_short_r, mark_short_nxt;
  err_t                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic [POS_BITS-1:0] pos_w;
  logic [31:0]         frame_w;
  logic                mark_short_w;
  err_t                err_w;
  logic [4:0]          bit_idx;
  logic                out_free;
  logic                keep;
  status_t             status_w;

  // Result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  // Only the final interval needs the result slot
  assign pop      = head_valid && (!head_data.last || out_free);
  // Odd positions 3..65 carry bits 0..31
  assign bit_idx  = 5'(pos_r[POS_BITS-1:1] - 1'b1);

  // Apply one interval to the frame state
  always_comb begin
    pos_w        = pos_r;
    frame_w      = frame_r;
    mark_short_w = mark_short_r;
    err_w        = err_r;
    if (pos_r < POS_BITS'(FRAME_INTERVALS)) begin
      if (pos_r == '0) begin
        if (!head_data.leader_mark_ok && err_r == ERR_NONE) begin
          err_w = ERR_LEADER;
        end
      end else if (pos_r == POS_BITS'(1)) begin
        if (!head_data.leader_space_ok && err_r == ERR_NONE) begin
          err_w = ERR_LEADER;
        end
      end else if (!pos_r[0]) begin
        mark_short_w = head_data.short_ok;
      end else begin
        if (mark_short_r && head_data.long_ok) begin
          frame_w[bit_idx] = 1'b1;
        end else if (mark_short_r && head_data.short_ok) begin
          frame_w[bit_idx] = 1'b0;
        end else if (err_r == ERR_NONE) begin
          err_w = ERR_BIT;
        end
      end
      pos_w = pos_r + 1'b1;
    end
  end

  // Grade the finished frame
  always_comb begin
    keep = 1'b0;
    if (pos_w < POS_BITS'(FRAME_INTERVALS)) begin
      status_w = ST_TOO_SHORT;
    end else if (err_w == ERR_LEADER) begin
      status_w = ST_BAD_LEADER;
    end else if (err_w != ERR_NONE) begin
      status_w = ST_BAD_BIT;
    end else begin
      keep = 1'b1;
      if ((frame_w[7:0] == (~frame_w[15:8] & BYTE_MASK)) &&
          (frame_w[23:16] == (~frame_w[31:24] & BYTE_MASK))) begin
        status_w = ST_OK;
      end else begin
        status_w = ST_INV_MISMATCH;
      end
    end
  end

  // Commit state; load result and clear on the final interval
  always_comb begin
    pos_nxt        = pos_r;
    frame_nxt      = frame_r;
    mark_short_nxt = mark_short_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    if (pop) begin
      if (head_data.last) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.status    = status_w;
        out_data_nxt.address   = keep ? frame_w[7:0] : '0;
        out_data_nxt.command   = keep ? frame_w[23:16] : '0;
        out_data_nxt.code_word = keep ? frame_w : '0;
        pos_nxt                = '0;
        frame_nxt              = '0;
        mark_short_nxt         = 1'b0;
        err_nxt                = ERR_NONE;
      end else begin
        pos_nxt        = pos_w;
        frame_nxt      = frame_w;
        mark_short_nxt = mark_short_w;
        err_nxt        = err_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      frame_r      <= '0;
      mark_short_r <= 1'b0;
      err_r        <= ERR_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      frame_r      <= frame_nxt;
      mark_short_r <= mark_short_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Position never runs past a full frame
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_BITS'(FRAME_INTERVALS))
    else $error("frame position past end of frame");

  // Final interval returns the decoder to its idle state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_data.last |=> pos_r == '0 && err_r == ERR_NONE && frame_r == '0)
    else $error("state not cleared after final interval");

  // Ok status implies both inverse bytes match
  a_ok_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_OK |->
      out_data_r.address == ~out_data_r.code_word[15:8] &&
      out_data_r.command == ~out_data_r.code_word[31:24])
    else $error("ok status with inverse byte mismatch");

  // Too-short, bad-leader and bad-bit frames carry zero code word and address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_TOO_SHORT ||
      out_data_r.status == ST_BAD_LEADER || out_data_r.status == ST_BAD_BIT) |->
      out_data_r.code_word == '0 && out_data_r.address == '0)
    else $error("failed frame with nonzero fields");

  // Error is sticky while the frame runs
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE && !(pop && head_data.last) |=> $stable(err_r))
    else $error("recorded error changed mid frame");

endmodule

FILE: rtl/core/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder.
//
//   port group  dir  beat                                   flow control
//   in_         in   interval_us, last (one interval)       in_valid / in_stall
//   out_        out  status, address, command, code_word    out_valid / out_stall
//
// One interval per clock sustained while in_stall is low; an interval is classified
// by window compares on entry, waits in a two-entry queue and updates the frame state
// as it leaves the queue. A result is loaded into the output register on the edge its
// final interval leaves the queue; out_valid is registered and rises with that load.
// rst_n is synchronous and clears the queue, the frame state and out_valid.
// A stalled result holds the output register; non-final intervals keep draining,
// and in_stall rises only when the queue is full.
module nec_ir_frame_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  necir_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output necir_pkg::out_beat_t out_data
);
  import necir_pkg::*;

  class_t cls;
  class_t head_data;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  assign in_stall = q_full;

  necir_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  necir_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_data  (cls),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  necir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: tb/necir_frame_sb_pkg.sv
// Scoreboard for the NEC frame decoder: predicts each capture's result and checks it.
package necir_frame_sb_pkg;

  import necir_pkg::*;

  class frame_checker;
    // Predicted decoder state for the capture in progress
    logic [POS_BITS-1:0] position;
    logic [31:0]         frame_word;
    logic                mark_short;
    err_t                first_err;

    // Results predicted but not yet seen at the output
    out_beat_t expected_frames[$];
    int unsigned n_errors;

    function new();
      clear_frame();
      n_errors = 0;
    endfunction

    function void clear_frame();
      position   = '0;
      frame_word = '0;
      mark_short = 1'b0;
      first_err  = ERR_NONE;
    endfunction

    static function bit in_span(int unsigned t, int lo, int hi);
      return t >= lo && t <= hi;
    endfunction

    // Advance the prediction by one accepted interval beat
    function void take_interval(in_beat_t b);
      int unsigned t;
      logic [4:0]  bit_idx;
      out_beat_t   exp;
      status_t     st;
      t = b.interval_us;
      if (position < FRAME_INTERVALS) begin
        if (position == 0) begin
          if (!in_span(t, LEADER_MARK_LO, LEADER_MARK_HI) && first_err == ERR_NONE)
            first_err = ERR_LEADER;
        end else if (position == 1) begin
          if (!in_span(t, LEADER_SPACE_LO, LEADER_SPACE_HI) && first_err == ERR_NONE)
            first_err = ERR_LEADER;
        end else if (!position[0]) begin
          mark_short = in_span(t, SHORT_LO, SHORT_HI);
        end else begin
          // Space closes a pair: short-long is 1, short-short is 0
          bit_idx = 5'((int'(position) - 3) >> 1);
          if (mark_short && in_span(t, LONG_LO, LONG_HI))
            frame_word[bit_idx] = 1'b1;
          else if (mark_short && in_span(t, SHORT_LO, SHORT_HI))
            frame_word[bit_idx] = 1'b0;
          else if (first_err == ERR_NONE)
            first_err = ERR_BIT;
        end
        position = position + 1'b1;
      end
      if (!b.last) return;

      // Final interval: form the status and the fields it keeps
      exp = '0;
      if (position < FRAME_INTERVALS) begin
        st = ST_TOO_SHORT;
      end else if (first_err == ERR_LEADER) begin
        st = ST_BAD_LEADER;
      end else if (first_err != ERR_NONE) begin
        st = ST_BAD_BIT;
      end else begin
        st = (frame_word[15:8] == ~frame_word[7:0] &&
              frame_word[31:24] == ~frame_word[23:16]) ? ST_OK : ST_INV_MISMATCH;
        exp.address   = frame_word[7:0];
        exp.command   = frame_word[23:16];
        exp.code_word = frame_word;
      end
      exp.status = st;
      expected_frames.push_back(exp);
      clear_frame();
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_frame(out_beat_t got);
      out_beat_t exp;
      if (expected_frames.size() == 0) begin
        $error("unexpected result beat: status %0d code_word %h", got.status, got.code_word);
        n_errors++;
        return;
      end
      exp = expected_frames.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.address !== exp.address) begin
        $error("address expected %h actual %h", exp.address, got.address);
        n_errors++;
      end
      if (got.command !== exp.command) begin
        $error("command expected %h actual %h", exp.command, got.command);
        n_errors++;
      end
      if (got.code_word !== exp.code_word) begin
        $error("code_word expected %h actual %h", exp.code_word, got.code_word);
        n_errors++;
      end
    endfunction
  endclass

endpackage

FILE: tb/nec_ir_frame_decoder_tb.sv
// Testbench top for the NEC infrared frame decoder: drives captures and checks results.
module nec_ir_frame_decoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import necir_pkg::*;
  import necir_frame_sb_pkg::*;

  localparam int ITEMS_TOTAL = 1900;
  localparam int MAX_US      = 65535;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  frame_checker frames = new();
  in_beat_t     capture_beats[$];
  int           in_idle_pct  = 0;
  int           out_idle_pct = 0;
  int           items_sent   = 0;

  nec_ir_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("FAIL nec_ir_frame_decoder");
    $finish;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) frames.check_frame(out_data);
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Present one interval beat, idling first at random, and hold it until taken
  task automatic send_beat(input logic [INTERVAL_BITS-1:0] t, input logic lst);
    in_beat_t b;
    b = '{interval_us: t, last: lst};
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames.take_interval(b);
  endtask

  // Value inside a window, edges favored
  function automatic int pick_in(int lo, int hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Value outside a window, edges and extremes favored
  function automatic int pick_out(int lo, int hi);
    case ($urandom_range(5))
      0:       return 0;
      1:       return lo - 1;
      2:       return hi + 1;
      3:       return MAX_US;
      4:       return $urandom_range(lo - 1, 0);
      default: return $urandom_range(MAX_US, hi + 1);
    endcase
  endfunction

  // Data space that fits neither the short nor the long window
  function automatic int pick_bad_space();
    case ($urandom_range(4))
      0:       return $urandom_range(SHORT_LO - 1, 0);
      1:       return $urandom_range(LONG_LO - 1, SHORT_HI + 1);
      2:       return $urandom_range(MAX_US, LONG_HI + 1);
      3:       return $urandom_range(1) ? SHORT_HI + 1 : LONG_LO - 1;
      default: return $urandom_range(1) ? LONG_HI + 1 : SHORT_LO - 1;
    endcase
  endfunction

  // Build a frame: random address and command, optional corruption, cut and tail
  task automatic build_frame(input int n_bad, input int bad_lo, input int bad_hi,
                             input bit mismatch, input int cut_len, input int n_extra);
    int          iv[FRAME_INTERVALS];
    logic [7:0]  adr;
    logic [7:0]  cmd;
    logic [31:0] word;
    int          p;
    int          len;
    adr  = 8'($urandom);
    cmd  = 8'($urandom);
    word = {~cmd, cmd, ~adr, adr};
    if (mismatch) word = word ^ (32'd1 << $urandom_range(31));
    iv[0] = pick_in(LEADER_MARK_LO, LEADER_MARK_HI);
    iv[1] = pick_in(LEADER_SPACE_LO, LEADER_SPACE_HI);
    for (int k = 0; k < 32; k++) begin
      iv[2 + 2 * k] = pick_in(SHORT_LO, SHORT_HI);
      iv[3 + 2 * k] = word[k] ? pick_in(LONG_LO, LONG_HI) : pick_in(SHORT_LO, SHORT_HI);
    end
    // Corrupt chosen intervals according to their role in the frame
    for (int k = 0; k < n_bad; k++) begin
      p = $urandom_range(bad_hi, bad_lo);
      if (p == 0)        iv[p] = pick_out(LEADER_MARK_LO, LEADER_MARK_HI);
      else if (p == 1)   iv[p] = pick_out(LEADER_SPACE_LO, LEADER_SPACE_HI);
      else if (p[0] == 0) iv[p] = pick_out(SHORT_LO, SHORT_HI);
      else               iv[p] = pick_bad_space();
    end
    len = (cut_len > 0) ? cut_len : FRAME_INTERVALS;
    capture_beats.delete();
    for (int k = 0; k < len; k++)
      capture_beats.push_back('{interval_us: INTERVAL_BITS'(iv[k]), last: 1'b0});
    for (int k = 0; k < n_extra; k++)
      capture_beats.push_back('{interval_us: INTERVAL_BITS'($urandom), last: 1'b0});
    capture_beats[capture_beats.size() - 1].last = 1'b1;
    items_sent += len;
  endtask

  // Capture of random intervals, 1 to 70 beats long
  task automatic build_noise();
    int len;
    len = $urandom_range(70, 1);
    capture_beats.delete();
    for (int k = 0; k < len; k++)
      capture_beats.push_back('{interval_us: INTERVAL_BITS'($urandom), last: 1'b0});
    capture_beats[len - 1].last = 1'b1;
    items_sent += (len < FRAME_INTERVALS) ? len : FRAME_INTERVALS;
  endtask

  // Hold the sender until every predicted result has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames.expected_frames.size() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int n_caps;
    n_caps = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short captures: extremes and leader and data window edges, all too short
    send_beat('0, 1'b1);
    send_beat(INTERVAL_BITS'(MAX_US), 1'b1);
    send_beat(16'd9000, 1'b0);
    send_beat(16'd4500, 1'b1);
    send_beat(INTERVAL_BITS'(LEADER_MARK_LO - 1), 1'b0);
    send_beat(INTERVAL_BITS'(LEADER_SPACE_HI + 1), 1'b1);
    send_beat(INTERVAL_BITS'(LEADER_MARK_HI), 1'b0);
    send_beat(INTERVAL_BITS'(LEADER_SPACE_LO), 1'b0);
    send_beat(INTERVAL_BITS'(SHORT_LO), 1'b0);
    send_beat(INTERVAL_BITS'(LONG_HI), 1'b0);
    send_beat(INTERVAL_BITS'(SHORT_HI), 1'b0);
    send_beat(INTERVAL_BITS'(LONG_LO - 1), 1'b1);
    send_beat(INTERVAL_BITS'(LEADER_MARK_HI + 1), 1'b0);
    send_beat(INTERVAL_BITS'(MAX_US), 1'b0);
    send_beat(INTERVAL_BITS'(SHORT_HI + 1), 1'b0);
    send_beat(INTERVAL_BITS'(SHORT_LO), 1'b1);
    drain_results();

    // Three idling regimes, each closed by a full drain
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 74 : 0;
      out_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 13 : 0;
      while (items_sent < (ph + 1) * ITEMS_TOTAL / 3) begin
        kind = (n_caps < 8) ? n_caps : $urandom_range(11);
        case (kind)
          0:       build_frame(0, 0, 0, 1'b0, 0, 0);
          1:       build_frame(1, 0, 1, 1'b0, 0, 0);
          2:       build_frame(1, 2, 65, 1'b0, 0, 0);
          3:       build_frame(0, 0, 0, 1'b1, 0, 0);
          4:       build_frame(0, 0, 0, 1'b0, $urandom_range(65, 1), 0);
          5:       build_frame(3, 0, 65, 1'b0, 0, $urandom_range(4, 1));
          6:       build_frame(2, 0, 65, 1'b0, $urandom_range(65, 1), 0);
          7:       build_noise();
          8:       build_frame(0, 0, 0, 1'b1, 0, $urandom_range(3));
          9:       build_frame($urandom_range(2, 1), 2, 65, 1'b0, 0, 0);
          default: build_frame(0, 0, 0, 1'b0, 0, $urandom_range(3));
        endcase
        n_caps++;
        foreach (capture_beats[k]) send_beat(capture_beats[k].interval_us,
                                             capture_beats[k].last);
      end
      drain_results();
    end

    // Let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    if (frames.n_errors == 0) begin
      $display("PASS nec_ir_frame_decoder");
    end else begin
      $display("FAIL nec_ir_frame_decoder");
    end
    $finish;
  end

endmodule
